FILE: hw/rtl/stcf_pkg.sv
// shared types and constants of the strip time cluster finder
`timescale 1ns / 1ps
`default_nettype none
package stcf_pkg;
  localparam int unsigned NumStripsDef = 2048;
  localparam int unsigned MaxRunDef    = 32;
  localparam int unsigned StripW       = 11;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned IndexW       = 24;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] CfgDeltaT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWrapFront = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWrapBack  = 2'd2;

  localparam logic ReqHit   = 1'b0;
  localparam logic ReqFlush = 1'b1;

  // one stored strip entry: active bit, hit index, hit time
  typedef struct packed {
    logic              active;
    logic [IndexW-1:0] index;
    logic [TimeW-1:0]  hit_time;
  } entry_t;

  localparam int unsigned EntryW = 1 + IndexW + TimeW;
endpackage
`default_nettype wire

FILE: hw/rtl/stcf_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module stcf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/strip_time_cluster_finder.sv
// top level of the strip time cluster finder: sequencer around the strip memory
// sequencing: a hit that closes nothing reads and decides its own strip, then its left and
//   right neighbours, stores its entry and returns to idle; at a side edge only the
//   neighbour inside the side is checked, and a flush checks only its own strip
// a closing run reads and checks strip by strip to the left and then to the right until
//   an idle strip or the side's bounds stop the scan, then reads and clears each strip of
//   the run, waiting while the output register is still full
// throughput: one item at a time, set by the single read port of the strip memory
// reset: after rst_ni the block sweeps the memory clearing every active bit, and takes no item until that pass is done
`timescale 1ns / 1ps
`default_nettype none
module strip_time_cluster_finder
  import stcf_pkg::*;
#(
  parameter int unsigned NUM_STRIPS = NumStripsDef,
  parameter int unsigned MAX_RUN    = MaxRunDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: strip[10:0], hit_time[42:11], hit_index[66:43], zero fill to 72
  input  wire logic [71:0]         s_axis_tdata,
  // tuser: req_type
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: member_index[23:0], member_strip[34:24], cluster_truncated[35], fill to 40
  output logic [39:0]              m_axis_tdata,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned AW   = $clog2(NUM_STRIPS);
  localparam int unsigned HALF = NUM_STRIPS / 2;
  localparam int unsigned RW   = $clog2(MAX_RUN + 1);

  // state codes
  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRd    = 4'd2;  // read issued for a check
  localparam logic [3:0] StChk   = 4'd3;  // data back, decide
  localparam logic [3:0] StLRd   = 4'd4;
  localparam logic [3:0] StLChk  = 4'd5;
  localparam logic [3:0] StRRd   = 4'd6;
  localparam logic [3:0] StRChk  = 4'd7;
  localparam logic [3:0] StERd   = 4'd8;
  localparam logic [3:0] StEChk  = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;
  localparam logic [3:0] StStore = 4'd11;

  logic [3:0] st_q, st_d;

  // config
  logic [TimeW-1:0] delta_q;
  logic             wrapf_q, wrapb_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0; wrapf_q <= 1'b0; wrapb_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDeltaT:    delta_q <= cfg_data_i;
        CfgWrapFront: wrapf_q <= cfg_data_i[0];
        CfgWrapBack:  wrapb_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [EntryW-1:0] rdata_raw;
  stcf_ram #(.Width(EntryW), .Depth(NUM_STRIPS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  // item registers
  logic              req_q;
  logic [AW-1:0]     ch_q;
  logic [TimeW-1:0]  t_q;
  logic [IndexW-1:0] idx_q;
  logic [1:0]        phase_q;   // 0 own, 1 left, 2 right
  logic [AW-1:0]     cur_q;     // strip under check
  // run scan
  logic [AW-1:0]     base_q, size_q, off_q;  // size_q holds size-1
  logic              wrap_q;
  logic [AW-1:0]     ls_q, rs_q, k_q, len_q, soff_q;
  logic [RW-1:0]     emit_q;
  logic              trunc_q;
  logic [AW:0]       init_q;
  // output register
  logic              ov_q;
  logic [IndexW-1:0] o_idx_q;
  logic [AW-1:0]     o_strip_q;
  logic              o_last_q, o_trunc_q;

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0, o_trunc_q, StripW'(o_strip_q), o_idx_q};
  assign m_axis_tlast  = o_last_q;

  logic [AW-1:0] in_ch;
  logic          in_ok;
  assign in_ch = s_axis_tdata[AW-1:0];
  assign in_ok = (32'(s_axis_tdata[StripW-1:0]) < 32'(NUM_STRIPS));

  // neighbour position helpers (offsets relative to side base, size_q = size-1)
  logic [AW-1:0] lpos, rpos, epos;
  logic          lcan, rcan;
  always_comb begin
    lcan = 1'b0; lpos = '0;
    if ((ls_q + 1'b1) <= size_q) begin
      if (ls_q < off_q) begin lcan = 1'b1; lpos = off_q - ls_q - 1'b1; end
      else if (wrap_q) begin lcan = 1'b1; lpos = off_q + size_q - ls_q; end
    end
    rcan = 1'b0; rpos = '0;
    if ((rs_q + 1'b1) <= size_q) begin
      if ((AW+1)'(off_q) + (AW+1)'(rs_q) + 1'b1 <= (AW+1)'(size_q)) begin
        rcan = 1'b1; rpos = off_q + rs_q + 1'b1;
      end else if (wrap_q) begin
        rcan = 1'b1; rpos = off_q + rs_q - size_q;
      end
    end
    // soff + k modulo size
    if ((AW+1)'(soff_q) + (AW+1)'(k_q) > (AW+1)'(size_q))
      epos = soff_q + k_q - size_q - 1'b1;
    else
      epos = soff_q + k_q;
  end

  logic [TimeW-1:0] gap;
  logic             is_old;
  assign gap    = t_q - rdata.hit_time;
  assign is_old = (t_q >= rdata.hit_time) && (gap > delta_q);

  // next phase of a hit after a check
  function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic [AW-1:0] c);
    logic [1:0] n;
    n = 2'd3;
    if (ph == 2'd0 && c != '0 && 32'(c) != HALF) n = 2'd1;
    else if (ph <= 2'd1 && 32'(c) != HALF - 1 && 32'(c) != NUM_STRIPS - 1) n = 2'd2;
    return n;
  endfunction

  logic [1:0] nph;
  assign nph = next_phase(phase_q, ch_q);

  // checked strip starts a run closure
  logic close_now;
  assign close_now = rdata.active && (req_q == ReqFlush || is_old);

  // member of the run is loaded into the output register
  logic out_load;
  assign out_load = (st_q == StEChk) && (32'(k_q) < 32'(emit_q));

  always_comb begin
    st_d = st_q; we = 1'b0; waddr = '0; wdata = '0; raddr = cur_q;
    case (st_q)
      StInit: begin we = 1'b1; waddr = init_q[AW-1:0];
        if (init_q == (AW+1)'(NUM_STRIPS - 1)) st_d = StIdle; end
      StIdle: if (s_axis_tvalid && in_ok) st_d = StRd;
      StRd:   st_d = StChk;
      StChk: begin
        if (close_now) st_d = StLRd;
        else if (req_q == ReqFlush) st_d = StIdle;
        else if (nph == 2'd3) st_d = StStore;
        else st_d = StRd;
      end
      StLRd:  begin raddr = base_q + lpos; st_d = lcan ? StLChk : StRRd; end
      StLChk: st_d = rdata.active ? StLRd : StRRd;
      StRRd:  begin raddr = base_q + rpos; st_d = rcan ? StRChk : StERd; end
      StRChk: st_d = rdata.active ? StRRd : StERd;
      StERd:  begin raddr = base_q + epos; st_d = StEChk; end
      StEChk: begin we = 1'b1; waddr = base_q + epos; st_d = StOut; end
      StOut: if (!ov_q || m_axis_tready) begin
        if (k_q != len_q) st_d = StERd;
        else if (req_q == ReqFlush) st_d = StIdle;
        else if (nph == 2'd3) st_d = StStore;
        else st_d = StRd;
      end
      StStore: begin we = 1'b1; waddr = ch_q;
        wdata = '{active: 1'b1, index: idx_q, hit_time: t_q}; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; init_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) ov_q <= 1'b1;
      else if (ov_q && m_axis_tready) ov_q <= 1'b0;
      case (st_q)
        StInit: init_q <= init_q + 1'b1;
        StIdle: if (s_axis_tvalid && in_ok) begin
          req_q <= s_axis_tuser; ch_q <= in_ch; cur_q <= in_ch;
          t_q <= s_axis_tdata[42:11]; idx_q <= s_axis_tdata[66:43];
          phase_q <= 2'd0;
        end
        StChk: begin
          if (close_now) begin
            if (32'(cur_q) < HALF) begin
              base_q <= '0; off_q <= cur_q; wrap_q <= wrapf_q;
              size_q <= AW'(HALF - 1);
            end else begin
              base_q <= AW'(HALF); off_q <= cur_q - AW'(HALF); wrap_q <= wrapb_q;
              size_q <= AW'(NUM_STRIPS - HALF - 1);
            end
            ls_q <= '0; rs_q <= '0;
          end else if (req_q != ReqFlush && nph != 2'd3) begin
            phase_q <= nph;
            cur_q <= (nph == 2'd1) ? ch_q - 1'b1 : ch_q + 1'b1;
          end
        end
        StLChk: if (rdata.active) ls_q <= ls_q + 1'b1;
        StRRd: if (!rcan) begin
          k_q <= '0;
          if ((AW+1)'(ls_q) + (AW+1)'(rs_q) >= (AW+1)'(size_q)) begin
            soff_q <= '0; len_q <= size_q;
          end else begin
            soff_q <= (off_q >= ls_q) ? off_q - ls_q : off_q + size_q + 1'b1 - ls_q;
            len_q <= ls_q + rs_q;
          end
        end
        StRChk: if (rdata.active) rs_q <= rs_q + 1'b1;
                else begin
          k_q <= '0;
          soff_q <= (off_q >= ls_q) ? off_q - ls_q : off_q + size_q + 1'b1 - ls_q;
          len_q <= ls_q + rs_q;
        end
        StERd: begin
          // len_q holds len-1
          trunc_q <= (32'(len_q) >= MAX_RUN);
          emit_q  <= (32'(len_q) >= MAX_RUN) ? RW'(MAX_RUN) : RW'(len_q + 1'b1);
        end
        StEChk: if (out_load) begin
          o_idx_q <= rdata.index; o_strip_q <= base_q + epos;
          o_last_q <= (32'(k_q) + 1 == 32'(emit_q)); o_trunc_q <= trunc_q;
        end
        StOut: if (!ov_q || m_axis_tready) begin
          if (k_q == len_q) begin
            if (req_q != ReqFlush && nph != 2'd3) begin
              phase_q <= nph;
              cur_q <= (nph == 2'd1) ? ch_q - 1'b1 : ch_q + 1'b1;
            end
          end else k_q <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
